@@ rtl/core/sfc_pkg.sv @@
// Shared constants, register indexes and types of the sync frame checker relay.
// Used by the parser, the emitter, the checker and the top level; depends on nothing.
package sfc_pkg;

    localparam int MAX_FRAME = 64;
    localparam int HDR_BYTES = 3;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int POS_W     = $clog2(MAX_FRAME);
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KIND_A_ID   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_KIND_A_LEN  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_KIND_B_ID   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_KIND_B_LEN  = CFG_IDX_W'(5);

    // frame store addresses of the header bytes
    localparam logic [POS_W-1:0] POS_SYNC_FIRST  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_ID          = POS_W'(2);
    localparam logic [POS_W-1:0] POS_PAYLOAD     = POS_W'(HDR_BYTES);

    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(5);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

    // handover from parser to emitter when a frame checks
    typedef struct packed {
        logic             start;
        logic             kind;
        logic [POS_W-1:0] last_idx;
    } t_emit_cmd;

    // saturate a length register to the legal range, return index of the last byte
    function automatic logic [POS_W-1:0] last_index(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] sat;
        logic [LEN_W-1:0] dec;
        sat = len;
        if (len < MIN_LEN) begin
            sat = MIN_LEN;
        end else if (len > MAX_LEN) begin
            sat = MAX_LEN;
        end
        dec = sat - LEN_W'(1);
        return dec[POS_W-1:0];
    endfunction

endpackage

@@ rtl/core/sfc_ram.sv @@
// Simple dual-port frame store: one write port, one read port, registered read data.
// Generic; no package dependency.
module sfc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/sfc_parse.sv @@
// Byte parser: sync hunt, identifier match, payload collection and checksum test.
// Writes frame bytes to the frame store, the checksum only if good; depends on sfc_pkg.
module sfc_parse
    import sfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_accept,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_wr_en,
    output logic [POS_W-1:0]     o_wr_addr,
    output t_emit_cmd            o_cmd
);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_ID,
        PH_DATA,
        PH_CHECK
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_kind, n_kind;
    logic [POS_W-1:0]  r_lm1, n_lm1;
    logic [POS_W-1:0]  pos_inc;

    logic [BYTE_W-1:0] r_sync1, r_sync2, r_a_id, r_b_id;
    logic [LEN_W-1:0]  r_a_len, r_b_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync1 <= BYTE_W'(8'hAA);
            r_sync2 <= BYTE_W'(8'h55);
            r_a_id  <= BYTE_W'(1);
            r_a_len <= LEN_W'(8);
            r_b_id  <= BYTE_W'(2);
            r_b_len <= LEN_W'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync1 <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync2 <= i_cfg_data;
                CFG_KIND_A_ID:   r_a_id  <= i_cfg_data;
                CFG_KIND_A_LEN:  r_a_len <= i_cfg_data[LEN_W-1:0];
                CFG_KIND_B_ID:   r_b_id  <= i_cfg_data;
                CFG_KIND_B_LEN:  r_b_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pos_inc = r_pos + POS_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_kind    = r_kind;
        n_lm1     = r_lm1;
        o_wr_en   = 1'b0;
        o_wr_addr = r_pos;
        o_cmd     = '0;
        if (i_accept) begin
            case (r_phase)
                PH_SYNC2: begin
                    if (i_rx_byte == r_sync2) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = POS_SYNC_SECOND;
                        n_phase   = PH_ID;
                    end else begin
                        // mismatch is not retried as a first sync byte
                        n_phase = PH_SYNC1;
                        n_pos   = '0;
                        n_sum   = '0;
                    end
                end
                PH_ID: begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = POS_ID;
                    if (i_rx_byte == r_a_id) begin
                        n_kind  = 1'b0;
                        n_lm1   = last_index(r_a_len);
                        n_pos   = POS_PAYLOAD;
                        n_sum   = i_rx_byte;
                        n_phase = PH_DATA;
                    end else if (i_rx_byte == r_b_id) begin
                        n_kind  = 1'b1;
                        n_lm1   = last_index(r_b_len);
                        n_pos   = POS_PAYLOAD;
                        n_sum   = i_rx_byte;
                        n_phase = PH_DATA;
                    end else begin
                        n_phase = PH_SYNC1;
                        n_pos   = '0;
                        n_sum   = '0;
                    end
                end
                PH_DATA: begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pos;
                    n_sum     = r_sum + i_rx_byte;
                    n_pos     = pos_inc;
                    if (pos_inc >= r_lm1) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (i_rx_byte == r_sum) begin
                        o_wr_en        = 1'b1;
                        o_wr_addr      = r_pos;
                        o_cmd.start    = 1'b1;
                        o_cmd.kind     = r_kind;
                        o_cmd.last_idx = r_pos;
                    end
                    n_phase = PH_SYNC1;
                    n_pos   = '0;
                    n_sum   = '0;
                end
                default: begin
                    n_pos = '0;
                    n_sum = '0;
                    if (i_rx_byte == r_sync1) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = POS_SYNC_FIRST;
                        n_phase   = PH_SYNC2;
                    end else begin
                        n_phase = PH_SYNC1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_pos   <= '0;
            r_sum   <= '0;
            r_kind  <= 1'b0;
            r_lm1   <= last_index(MIN_LEN);
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_kind  <= n_kind;
            r_lm1   <= n_lm1;
        end
    end

endmodule

@@ rtl/core/sfc_emit.sv @@
// Frame emitter: reads a checked frame back from the store and drives the output item
// register. One read in flight at a time; depends on sfc_pkg.
module sfc_emit
    import sfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_emit_cmd         i_cmd,
    output logic              o_busy,
    output logic              o_rd_en,
    output logic [POS_W-1:0]  o_rd_addr,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [BYTE_W-1:0] o_tdata,
    output logic              o_tuser,
    output logic              o_tlast
);

    typedef enum logic {
        EM_IDLE,
        EM_RUN
    } t_em_state;

    t_em_state         r_state;
    logic [POS_W-1:0]  r_addr;
    logic [POS_W-1:0]  r_last_idx;
    logic              r_kind;
    logic              r_pend;
    logic              r_pend_last;
    logic              r_tvalid;
    logic [BYTE_W-1:0] r_tdata;
    logic              r_tuser;
    logic              r_tlast;
    logic              issue;

    // output slot is free next cycle if empty now or taken now
    assign issue     = (r_state == EM_RUN) && !r_pend && (!r_tvalid || i_tready);
    assign o_rd_en   = issue;
    assign o_rd_addr = r_addr;
    assign o_busy    = (r_state == EM_RUN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EM_IDLE;
            r_pend      <= 1'b0;
            r_tvalid    <= 1'b0;
            r_addr      <= '0;
            r_last_idx  <= '0;
            r_kind      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            case (r_state)
                EM_IDLE: begin
                    if (i_cmd.start) begin
                        r_state    <= EM_RUN;
                        r_addr     <= '0;
                        r_last_idx <= i_cmd.last_idx;
                        r_kind     <= i_cmd.kind;
                    end
                end
                EM_RUN: begin
                    if (issue) begin
                        r_pend_last <= (r_addr == r_last_idx);
                        if (r_addr == r_last_idx) begin
                            r_state <= EM_IDLE;
                        end else begin
                            r_addr <= r_addr + POS_W'(1);
                        end
                    end
                end
                default: r_state <= EM_IDLE;
            endcase

            r_pend <= issue;
            if (r_pend) begin
                r_tvalid <= 1'b1;
                r_tdata  <= i_rd_data;
                r_tuser  <= r_kind;
                r_tlast  <= r_pend_last;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

endmodule

@@ rtl/core/sync_frame_checker_relay.sv @@
// Sync frame checker relay, top level: parser, frame store and emitter.
// Depends on sfc_pkg, sfc_parse, sfc_ram and sfc_emit.
//
// Usage:
//   s_axis_* carries received bytes, one item per byte. m_axis_* carries the
//   bytes of each frame that passed its checksum: both sync bytes, identifier,
//   payload and checksum in received order, tuser = frame kind, tlast on the
//   checksum byte. i_cfg_* writes the six configuration registers; it is
//   always ready out of reset.
//   Input bytes are taken one per cycle while no frame is being emitted. When
//   the checksum byte of a good frame is taken, the emitter starts, issues a
//   store read and loads the read data into the output item register; the frame
//   then leaves one item after another, with one store read in flight at a time,
//   and the input is held off while the frame is read from the store. Bad frames
//   produce nothing and do not hold the input off.
//   Reset (synchronous, active low) restores the register defaults and starts
//   the sync hunt; the frame store needs no clearing.
//   If the receiver stalls, the current output item holds and emission pauses;
//   the input stays held off until the last store read of the frame is issued.
module sync_frame_checker_relay
    import sfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [BYTE_W-1:0]    m_axis_tdata,   // [7:0] tx_byte
    output logic [0:0]           m_axis_tuser,   // [0] frame_kind
    output logic                 m_axis_tlast    // last_of_frame
);

    t_emit_cmd         cmd;
    logic              busy;
    logic              accept;
    logic              wr_en;
    logic [POS_W-1:0]  wr_addr;
    logic              rd_en;
    logic [POS_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data;

    assign o_cfg_ready   = i_rst_n;
    assign s_axis_tready = i_rst_n && !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sfc_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_byte   (s_axis_tdata),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_cmd       (cmd)
    );

    sfc_ram #(
        .DEPTH (MAX_FRAME),
        .WIDTH (BYTE_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sfc_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_busy    (busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser[0]),
        .o_tlast   (m_axis_tlast)
    );

endmodule

@@ rtl/core/sfc_chk.sv @@
// Port-level checker for the sync frame checker relay, bound to the top level.
// Depends on sfc_pkg.
module sfc_chk
    import sfc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [BYTE_W-1:0] m_axis_tdata,
    input logic [0:0]        m_axis_tuser,
    input logic              m_axis_tlast
);

    // stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // a frame part-way out keeps the input closed
    a_in_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open while a frame is mid-emission");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind sync_frame_checker_relay sfc_chk u_sfc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
